// ===== design/ptp_pkg.sv =====
// ptp_pkg: shared types and constants for the peak-to-peak current meter
// holds controller states, command/status structs and register indexes
// no dependencies
`default_nettype none

package ptp_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register widths
  localparam int MV_W   = 10;
  localparam int MA_W   = 16;
  localparam int RATE_W = 16;

  // rms factor 0.3535 in Q16, and offset in mA
  localparam int          Q16_W     = 15;
  localparam int          Q16_SHIFT = 16;
  localparam logic [14:0] RMS_Q16   = 15'd23167;
  localparam logic [6:0]  OFFSET_MA = 7'd98;

  // reset values of the registers
  localparam logic [MV_W-1:0]   MV_RESET   = 10'd66;
  localparam logic [MA_W-1:0]   MAXMA_RESET = 16'hFFFF;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MV_PER_AMP     = 2'd0,
    REG_MAX_ALLOWED_MA = 2'd1,
    REG_READINGS_RATE  = 2'd2
  } ptp_reg_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUTE,
    S_DIV,
    S_COMMIT
  } ptp_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sample;
    logic mul;
    logic div_step;
    logic commit;
  } ptp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close;
    logic div_last;
    logic out_free;
  } ptp_stat_t;

endpackage

`default_nettype wire

// ===== design/ptp_ctrl.sv =====
// ptp_ctrl: sequencing state machine of the peak-to-peak current meter
// depends on ptp_pkg (states, command and status structs)
`default_nettype none

module ptp_ctrl
  import ptp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ptp_stat_t stat,
  output ptp_cmd_t       cmd
);

  ptp_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (stat.close) begin
          cmd.mul    = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.sample = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ptp_dp.sv =====
// ptp_dp: datapath of the peak-to-peak current meter
// tracker, config registers, multiplier, serial divider, output register
// depends on ptp_pkg
`default_nettype none

module ptp_dp
  import ptp_pkg::*;
#(
  parameter int SAMPLE_BITS = 22
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ptp_cmd_t              cmd,
  output ptp_stat_t                  stat,
  // item payload
  input  wire logic                  action,
  input  wire logic [SAMPLE_BITS-1:0] sample_uv,
  input  wire logic                  window_elapsed,
  // result
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [MA_W-1:0]            consumption_ma,
  output logic                       over_limit,
  output logic                       report_due,
  output logic                       window_done,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = SB + Q16_W;
  localparam int QW     = PROD_W - Q16_SHIFT;
  localparam int CNT_W  = $clog2(QW);
  localparam int EXT_W  = (QW > MA_W) ? QW : MA_W + 1;

  // captured item
  logic          item_action;
  logic [SB-1:0] item_sample;
  logic          item_elapsed;

  // configuration registers
  logic [MV_W-1:0]   mv_per_amp;
  logic [MA_W-1:0]   max_allowed_ma;
  logic [RATE_W-1:0] readings_rate;

  // tracker state
  logic [SB-1:0]     peak_uv;
  logic [SB-1:0]     valley_uv;
  logic [SB-1:0]     swing_uv;
  logic [MA_W-1:0]   reading_ma;
  logic [RATE_W-1:0] read_count;

  // divider
  logic [QW-1:0]    div_n;
  logic [MV_W-1:0]  div_rem;
  logic [CNT_W-1:0] div_cnt;

  logic              item_close;
  logic [SB:0]       peak_sum;
  logic [SB:0]       valley_sum;
  logic [PROD_W-1:0] prod;
  logic [MV_W:0]     rem_sh;
  logic              rem_ge;
  logic [MV_W:0]     rem_new;
  logic [QW-1:0]     q_off;
  logic [EXT_W-1:0]  q_ext;
  logic [MA_W-1:0]   conv_ma;
  logic              count_wrap;

  assign cfg_ready  = 1'b1;
  assign item_close = item_action && item_elapsed;

  assign stat.close    = item_close;
  assign stat.div_last = (div_cnt == '0);
  assign stat.out_free = !out_valid || out_ready;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_per_amp     <= MV_RESET;
      max_allowed_ma <= MAXMA_RESET;
      readings_rate  <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ptp_reg_t'(cfg_index))
        REG_MV_PER_AMP:     mv_per_amp     <= cfg_data[MV_W-1:0];
        REG_MAX_ALLOWED_MA: max_allowed_ma <= cfg_data[MA_W-1:0];
        REG_READINGS_RATE:  readings_rate  <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action  <= action;
      item_sample  <= sample_uv;
      item_elapsed <= window_elapsed;
    end
  end

  // running averages toward the sample
  assign peak_sum   = {1'b0, peak_uv} + {1'b0, item_sample};
  assign valley_sum = {1'b0, valley_uv} + {1'b0, item_sample};

  // rms factor product, Q16 fraction dropped by wiring
  assign prod = PROD_W'(swing_uv) * PROD_W'(RMS_Q16);

  // restoring divide step
  assign rem_sh  = {div_rem, div_n[QW-1]};
  assign rem_ge  = rem_sh >= {1'b0, mv_per_amp};
  assign rem_new = rem_ge ? (rem_sh - {1'b0, mv_per_amp}) : rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      div_n   <= prod[PROD_W-1:Q16_SHIFT];
      div_rem <= '0;
      div_cnt <= CNT_W'(QW - 1);
    end else if (cmd.div_step) begin
      div_n   <= {div_n[QW-2:0], rem_ge};
      div_rem <= rem_new[MV_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // quotient minus offset, saturated
  assign q_off = div_n - QW'(OFFSET_MA);
  assign q_ext = EXT_W'(q_off);
  always_comb begin
    priority if (mv_per_amp == '0) begin
      conv_ma = '1;
    end else if (div_n <= QW'(OFFSET_MA)) begin
      conv_ma = '0;
    end else if (q_ext > EXT_W'({MA_W{1'b1}})) begin
      conv_ma = '1;
    end else begin
      conv_ma = q_ext[MA_W-1:0];
    end
  end

  assign count_wrap = read_count >= readings_rate;

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_uv    <= '0;
      valley_uv  <= '1;
      swing_uv   <= '0;
      reading_ma <= '0;
      read_count <= '0;
    end else begin
      if (cmd.sample) begin
        if (item_sample > peak_uv) begin
          peak_uv <= peak_sum[SB:1];
        end else if (item_sample < valley_uv) begin
          valley_uv <= valley_sum[SB:1];
        end
      end
      if (cmd.commit) begin
        if (item_close) begin
          peak_uv    <= '0;
          valley_uv  <= '1;
          reading_ma <= conv_ma;
        end else begin
          swing_uv <= (peak_uv > valley_uv) ? (peak_uv - valley_uv) : '0;
          if (!item_action) begin
            read_count <= count_wrap ? '0 : read_count + 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      consumption_ma <= item_close ? conv_ma : reading_ma;
      over_limit     <= !item_action && (reading_ma > max_allowed_ma);
      report_due     <= !item_action && count_wrap;
      window_done    <= item_close;
    end
  end

`ifndef SYNTHESIS
  // a result is never written over one still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("ptp_dp: result overwritten before taken");

  // a closing result carries no read flags
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_done) |-> (!over_limit && !report_due))
    else $error("ptp_dp: window close with read flags");

  // divider only runs for a window close
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> item_close)
    else $error("ptp_dp: divider stepped for a sampling request");

  // closing puts the tracker back to its start values
  assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && item_close) |=> (peak_uv == '0 && valley_uv == '1))
    else $error("ptp_dp: tracker not cleared on window close");
`endif

endmodule

`default_nettype wire

// ===== design/peak_to_peak_current_meter_top.sv =====
// Peak-to-peak current meter, top level: controller plus datapath
// Sampling requests: ROUTE, then COMMIT, which waits for a free output register.
// Window close: ROUTE, then DIV, where the restoring divider retires one quotient bit
// a cycle, then COMMIT. One request in flight at a time.
// Reset (synchronous): registers to defaults, peak 0, valley full scale, read counter 0.
`default_nettype none

module peak_to_peak_current_meter_top
  import ptp_pkg::*;
#(
  parameter int SAMPLE_BITS = 22
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   action,
  input  wire logic [SAMPLE_BITS-1:0] sample_uv,
  input  wire logic                   window_elapsed,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [MA_W-1:0]             consumption_ma,
  output logic                        over_limit,
  output logic                        report_due,
  output logic                        window_done,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  ptp_cmd_t  cmd;
  ptp_stat_t stat;

  // sequencing
  ptp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and state
  ptp_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (action),
    .sample_uv      (sample_uv),
    .window_elapsed (window_elapsed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .consumption_ma (consumption_ma),
    .over_limit     (over_limit),
    .report_due     (report_due),
    .window_done    (window_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

`default_nettype wire

// ===== verif/meter_tb_pkg.sv =====
// meter_tb_pkg: codes shared by the current meter testbench and its checker
// holds the action codes of an input request; no dependencies
package meter_tb_pkg;

  // action field of an input request
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_POLL = 1'b1;

endpackage

// ===== verif/meter_checker.sv =====
// meter_checker: watches the request, result and register channels of the current meter
// predicts each result from its own copy of the meter state and compares field by field
// depends on ptp_pkg and meter_tb_pkg
module meter_checker
  import ptp_pkg::*;
  import meter_tb_pkg::*;
#(
  parameter int SB = 22
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic                  action,
  input  wire logic [SB-1:0]         sample_uv,
  input  wire logic                  window_elapsed,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [MA_W-1:0]       consumption_ma,
  input  wire logic                  over_limit,
  input  wire logic                  report_due,
  input  wire logic                  window_done,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fails,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MA_W-1:0] ma;
    logic            over;
    logic            due;
    logic            done;
  } meter_result_t;

  meter_result_t expected_q[$];

  // register copies
  logic [MV_W-1:0]   mv_per_amp;
  logic [MA_W-1:0]   max_ma;
  logic [RATE_W-1:0] rate;

  // meter state copies
  logic [SB-1:0]     peak;
  logic [SB-1:0]     valley;
  logic [SB-1:0]     swing;
  logic [MA_W-1:0]   reading;
  logic [RATE_W-1:0] read_count;

  // swing in microvolts to milliamps, rms factor in q16, offset removed, saturated
  function automatic logic [MA_W-1:0] swing_to_ma(logic [SB-1:0] sw);
    longint unsigned prod, denom, q;
    if (mv_per_amp == '0) return '1;
    prod  = 64'(sw) * 64'(RMS_Q16);
    denom = 64'(mv_per_amp) << Q16_SHIFT;
    q     = prod / denom;
    if (q <= 64'(OFFSET_MA)) return '0;
    q = q - 64'(OFFSET_MA);
    return (q > 64'hFFFF) ? '1 : q[MA_W-1:0];
  endfunction

  // a sample above the peak or below the valley averages into it
  function automatic void track_sample(logic [SB-1:0] s);
    if (s > peak) begin
      peak = SB'(({1'b0, peak} + {1'b0, s}) >> 1);
    end else if (s < valley) begin
      valley = SB'(({1'b0, valley} + {1'b0, s}) >> 1);
    end
    swing = (peak > valley) ? peak - valley : '0;
  endfunction

  // advance the meter by one request and return the result it causes
  function automatic meter_result_t step_meter(logic act, logic [SB-1:0] s, logic el);
    meter_result_t r;
    r = '0;
    if (act == ACT_READ) begin
      track_sample(s);
      r.over = (reading > max_ma);
      if (read_count >= rate) begin
        r.due      = 1'b1;
        read_count = '0;
      end else begin
        read_count = read_count + 1'b1;
      end
    end else if (!el) begin
      track_sample(s);
    end else begin
      peak    = '0;
      valley  = '1;
      reading = swing_to_ma(swing);
      r.done  = 1'b1;
    end
    r.ma = reading;
    return r;
  endfunction

  // register writes, result compare, then prediction of the newly accepted request
  always @(posedge clk) begin
    meter_result_t got, want;
    if (rst) begin
      mv_per_amp = MV_RESET;
      max_ma     = MAXMA_RESET;
      rate       = RATE_RESET;
      peak       = '0;
      valley     = '1;
      swing      = '0;
      reading    = '0;
      read_count = '0;
      fails      = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MV_PER_AMP:     mv_per_amp = cfg_data[MV_W-1:0];
          REG_MAX_ALLOWED_MA: max_ma     = cfg_data[MA_W-1:0];
          REG_READINGS_RATE:  rate       = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{consumption_ma, over_limit, report_due, window_done};
        if (expected_q.size() == 0) begin
          $error("result with no request pending");
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.ma !== want.ma) begin
            $error("consumption_ma: expected %0d, got %0d", want.ma, got.ma);
            fails++;
          end
          if (got.over !== want.over) begin
            $error("over_limit: expected %0b, got %0b", want.over, got.over);
            fails++;
          end
          if (got.due !== want.due) begin
            $error("report_due: expected %0b, got %0b", want.due, got.due);
            fails++;
          end
          if (got.done !== want.done) begin
            $error("window_done: expected %0b, got %0b", want.done, got.done);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(step_meter(action, sample_uv, window_elapsed));
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/tb_peak_to_peak_current_meter_top.sv =====
// tb_peak_to_peak_current_meter_top: stimulus and verdict for the current meter
// drives requests and register writes under several idling phases; meter_checker compares
// depends on ptp_pkg, meter_tb_pkg, meter_checker and peak_to_peak_current_meter_top
module tb_peak_to_peak_current_meter_top
  import ptp_pkg::*;
  import meter_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS    = 22;
  localparam int WATCHDOG_LIMIT = 3000;
  // idle time before register writes, with margin over a window close
  localparam int DRAIN_CYCLES   = 32;
  localparam int MAX_GAP        = 40;
  localparam int PHASE_ITEMS    = 130;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   action;
  logic [SAMPLE_BITS-1:0] sample_uv;
  logic                   window_elapsed;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [MA_W-1:0]        consumption_ma;
  logic                   over_limit;
  logic                   report_due;
  logic                   window_done;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fails;
  int pending;
  int idle_pct;
  int stall_pct;
  int idle_cycles;

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  peak_to_peak_current_meter_top #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .sample_uv(sample_uv), .window_elapsed(window_elapsed),
    .out_valid(out_valid), .out_ready(out_ready),
    .consumption_ma(consumption_ma), .over_limit(over_limit),
    .report_due(report_due), .window_done(window_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  meter_checker #(
    .SB(SAMPLE_BITS)
  ) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .sample_uv(sample_uv), .window_elapsed(window_elapsed),
    .out_valid(out_valid), .out_ready(out_ready),
    .consumption_ma(consumption_ma), .over_limit(over_limit),
    .report_due(report_due), .window_done(window_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request, entered and left at a falling edge; valid stays high after accept
  task automatic send_item(input logic act, input logic [SAMPLE_BITS-1:0] s,
                           input logic el);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action         = act;
    sample_uv      = s;
    window_elapsed = el;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off requests until every expected result is in
  task automatic wait_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // quiesce, then write all registers plus the unused index
  task automatic program_registers(input logic [CFG_DATA_W-1:0] mv_word,
                                   input logic [CFG_DATA_W-1:0] limit_ma,
                                   input logic [CFG_DATA_W-1:0] rate_word);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{REG_MV_PER_AMP, REG_UNUSED, REG_MAX_ALLOWED_MA, REG_READINGS_RATE};
    val = '{mv_word, 16'h0001, limit_ma, rate_word};
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_index = idx[i];
      cfg_data  = val[i];
      cfg_valid = 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // samples weighted toward the extremes and small values
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return SAMPLE_BITS'($urandom_range(255));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly whole windows: read, some polls, close; the rest lone random requests
  task automatic run_windows(input int n_items);
    int sent;
    int polls;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(39) == 0) wait_results();
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom_range(1)), rand_sample(), 1'($urandom_range(1)));
        sent++;
      end else begin
        send_item(ACT_READ, rand_sample(), 1'($urandom_range(1)));
        sent++;
        polls = $urandom_range(1, 8);
        repeat (polls) begin
          if ($urandom_range(5) == 0) begin
            send_item(ACT_READ, rand_sample(), 1'($urandom_range(1)));
          end else begin
            send_item(ACT_POLL, rand_sample(), 1'b0);
          end
          sent++;
        end
        if ($urandom_range(7) != 0) begin
          send_item(ACT_POLL, rand_sample(), 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_READ;
    sample_uv      = '0;
    window_elapsed = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_MV_PER_AMP;
    cfg_data       = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: read ignores elapsed, extremes, sample equal to peak and valley
    send_item(ACT_READ, '0, 1'b1);
    send_item(ACT_READ, '1, 1'b0);
    send_item(ACT_POLL, 22'h1FFFFF, 1'b0);
    send_item(ACT_POLL, 22'h2AAAAA, 1'b0);
    send_item(ACT_POLL, 22'h155555, 1'b0);
    send_item(ACT_POLL, '1, 1'b1);
    send_item(ACT_READ, '0, 1'b0);
    // full scale swing, then close
    repeat (3) send_item(ACT_POLL, '1, 1'b0);
    repeat (3) send_item(ACT_POLL, '0, 1'b0);
    send_item(ACT_POLL, '0, 1'b1);
    // close on an empty window
    send_item(ACT_POLL, 22'h2AAAAA, 1'b1);
    repeat (3) send_item(ACT_READ, 22'h155555, 1'b0);
    wait_results();

    // largest divisor (upper data bits dropped), zero limit, report every read
    program_registers(16'hFFFF, 16'h0000, 16'h0000);
    run_windows(PHASE_ITEMS);

    // smallest divisor saturates, limit just below full, counter runs up
    program_registers(16'h0001, 16'hFFFE, 16'hFFFF);
    idle_pct = 59;
    run_windows(PHASE_ITEMS);

    // zero divisor, rate lowered under the running count
    program_registers(16'h0400, 16'd1000, 16'd3);
    idle_pct  = 0;
    stall_pct = 59;
    run_windows(PHASE_ITEMS);

    // mid-range settings, both sides idling
    program_registers(16'd1000, 16'($urandom_range(3000)), 16'($urandom_range(15)));
    idle_pct  = 33;
    stall_pct = 33;
    run_windows(PHASE_ITEMS);

    // drain and settle
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== peak_to_peak_current_meter_top.f =====
design/ptp_pkg.sv
design/ptp_ctrl.sv
design/ptp_dp.sv
design/peak_to_peak_current_meter_top.sv
verif/meter_tb_pkg.sv
verif/meter_checker.sv
verif/tb_peak_to_peak_current_meter_top.sv
